@@ rtl/ipv4dq_pkg.sv @@
// Package with the transaction types, constants and octet-closing function of the parser.
package ipv4dq_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] octet_a;
      logic [7:0] octet_b;
      logic [7:0] octet_c;
      logic [7:0] octet_d;
      logic       addr_valid;
   } rsp_type;

   typedef struct packed {
      logic [8:0]      digit_accum;
      logic [2:0]      octet_count;
      logic [3:0][7:0] octet_store;
      logic [4:0]      char_count;
      logic            error_seen;
   } parse_state_type;

   localparam logic [8:0] ACC_SAT    = 9'd256;
   localparam logic [2:0] NUM_OCTETS = 3'd4;
   localparam logic [4:0] MIN_LEN    = 5'd7;
   localparam logic [4:0] MAX_LEN    = 5'd15;
   localparam logic [4:0] LEN_SAT    = 5'd16;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Closing a fifth octet or one above 255 marks the address as broken.
   function automatic parse_state_type close_octet(parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.octet_count >= NUM_OCTETS) begin
         r.error_seen = 1'b1;
      end else if (s.digit_accum >= ACC_SAT) begin
         r.error_seen = 1'b1;
      end else begin
         r.octet_store[s.octet_count[1:0]] = s.digit_accum[7:0];
         r.octet_count = s.octet_count + 3'd1;
         r.digit_accum = '0;
      end
      return r;
   endfunction

endpackage

@@ rtl/ipv4dq_step.sv @@
// Combinational next-state and result logic for one character of the address text.
module ipv4dq_step (
   input  ipv4dq_pkg::parse_state_type state_cur,
   input  ipv4dq_pkg::req_type         item,
   output ipv4dq_pkg::parse_state_type state_next,
   output ipv4dq_pkg::rsp_type         result
);
   import ipv4dq_pkg::*;

   parse_state_type st;
   parse_state_type fin;
   logic [3:0]      digit_val;
   logic [11:0]     acc_next;
   logic            good;

   always_comb begin
      st        = state_cur;
      digit_val = item.character[3:0] - CHAR_ZERO[3:0];
      acc_next  = ({3'b000, state_cur.digit_accum} << 3) +
                  ({3'b000, state_cur.digit_accum} << 1) +
                  {8'h00, digit_val};

      if (st.char_count < LEN_SAT) begin
         st.char_count = st.char_count + 5'd1;
      end

      if (item.character == CHAR_DOT) begin
         st = close_octet(st);
      end else if (item.character inside {[CHAR_ZERO:CHAR_NINE]}) begin
         if (st.octet_count >= NUM_OCTETS) begin
            st.error_seen = 1'b1;
         end else if (acc_next > {3'b000, ACC_SAT}) begin
            st.digit_accum = ACC_SAT;
         end else begin
            st.digit_accum = acc_next[8:0];
         end
      end else begin
         st.error_seen = 1'b1;
      end

      fin  = close_octet(st);
      good = !fin.error_seen && (fin.octet_count == NUM_OCTETS) &&
             (fin.char_count >= MIN_LEN) && (fin.char_count <= MAX_LEN);

      result.octet_a    = good ? fin.octet_store[0] : 8'h00;
      result.octet_b    = good ? fin.octet_store[1] : 8'h00;
      result.octet_c    = good ? fin.octet_store[2] : 8'h00;
      result.octet_d    = good ? fin.octet_store[3] : 8'h00;
      result.addr_valid = good;

      state_next = item.last_char ? parse_state_type'('0) : st;
   end

endmodule

@@ rtl/ipv4_dotted_quad_parser_unit.sv @@
// Top level of the IPv4 dotted-quad text parser with input and result registers.
// Result path: the last character of an address is held in the input register, and its result
// is written to the result register and presented on rsp_.
// Throughput: one character per cycle; the input register and the result register
// decouple the two channels, and only a stalled result holds back a last character.
// Reset: synchronous, active high; it clears the parse state and both valid flags.
module ipv4_dotted_quad_parser_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ipv4dq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ipv4dq_pkg::rsp_type rsp_data
);
   import ipv4dq_pkg::*;

   logic            req_valid_ff;
   logic            req_valid_in;
   req_type         req_data_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   rsp_type         step_rsp;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_data_ff;
   logic            out_free;
   logic            step_fire;
   logic            accept;

   ipv4dq_step u_step (
      .state_cur  (state_ff),
      .item       (req_data_ff),
      .state_next (step_state),
      .result     (step_rsp)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = req_valid_ff && (!req_data_ff.last_char || out_free);
   assign req_stall = req_valid_ff && !step_fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_valid_in = accept || (req_valid_ff && !step_fire);
      state_in     = step_fire ? step_state : state_ff;
      if (step_fire && req_data_ff.last_char) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_data;
      end
      if (step_fire && req_data_ff.last_char) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ bench/ipv4_dotted_quad_parser_unit_tb.sv @@
// Self-checking testbench for the IPv4 dotted-quad text parser.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_unit_tb;
   import ipv4dq_pkg::*;

   typedef logic [7:0] char_q_type[$];

   localparam int unsigned LONG_HOLD = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type char_feed[$];
   rsp_type want_quads[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned queued_chars = 0;
   int unsigned faults = 0;
   int unsigned quads_checked = 0;
   int unsigned quads_valid = 0;

   logic [8:0] acc_q = '0;
   logic [2:0] closed_q = '0;
   logic [7:0] quad_q [4] = '{default: '0};
   logic [4:0] len_q = '0;
   logic       broken_q = 1'b0;

   ipv4_dotted_quad_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void finish_octet();
      if (closed_q >= NUM_OCTETS || acc_q >= ACC_SAT) begin
         broken_q = 1'b1;
      end else begin
         quad_q[closed_q[1:0]] = acc_q[7:0];
         closed_q = closed_q + 3'd1;
         acc_q = '0;
      end
   endfunction

   function automatic void parse_char(req_type it);
      int unsigned grown;
      rsp_type     quad;
      logic        ok;
      if (len_q < LEN_SAT) len_q = len_q + 5'd1;
      if (it.character == CHAR_DOT) begin
         finish_octet();
      end else if (it.character >= CHAR_ZERO && it.character <= CHAR_NINE) begin
         if (closed_q >= NUM_OCTETS) begin
            broken_q = 1'b1;
         end else begin
            grown = acc_q * 10 + (it.character - CHAR_ZERO);
            acc_q = (grown > ACC_SAT) ? ACC_SAT : grown[8:0];
         end
      end else begin
         broken_q = 1'b1;
      end
      if (it.last_char) begin
         finish_octet();
         ok = !broken_q && closed_q == NUM_OCTETS && len_q >= MIN_LEN && len_q <= MAX_LEN;
         quad.octet_a    = ok ? quad_q[0] : 8'd0;
         quad.octet_b    = ok ? quad_q[1] : 8'd0;
         quad.octet_c    = ok ? quad_q[2] : 8'd0;
         quad.octet_d    = ok ? quad_q[3] : 8'd0;
         quad.addr_valid = ok;
         want_quads.push_back(quad);
         acc_q = '0;
         closed_q = '0;
         quad_q = '{default: '0};
         len_q = '0;
         broken_q = 1'b0;
      end
   endfunction

   function automatic char_q_type number_text(int unsigned v);
      string      s;
      char_q_type t;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   task automatic add_text(input char_q_type txt);
      req_type it;
      foreach (txt[i]) begin
         it.character = txt[i];
         it.last_char = (i == txt.size() - 1);
         char_feed.push_back(it);
      end
      queued_chars += txt.size();
   endtask

   task automatic add_string(input string s);
      char_q_type txt;
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      add_text(txt);
   endtask

   // Random addresses: dotted octets, some malformed or mutated; the rest are pure noise.
   task automatic add_random_address();
      char_q_type  txt;
      char_q_type  part;
      int unsigned kind;
      int unsigned pick;
      int unsigned n_octets;
      int unsigned v;
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(255)));
      end else begin
         n_octets = (kind < 70) ? 4 : $urandom_range(1, 6);
         for (int k = 0; k < n_octets; k++) begin
            if (k > 0) txt.push_back(CHAR_DOT);
            pick = $urandom_range(99);
            if (pick >= 5) begin
               if (pick < 12) repeat ($urandom_range(1, 3)) txt.push_back(CHAR_ZERO);
               if (pick < 20)      v = $urandom_range(256, 999);
               else if (pick < 23) v = $urandom_range(1000, 99999);
               else if (pick < 30) v = ($urandom_range(1) != 0) ? 255 : 0;
               else                v = $urandom_range(255);
               part = number_text(v);
               foreach (part[i]) txt.push_back(part[i]);
            end
         end
         if (kind >= 70 && kind < 82) begin
            txt.insert($urandom_range(txt.size()), 8'($urandom_range(255)));
         end else if (kind >= 82 && kind < 88) begin
            txt.push_back(CHAR_DOT);
         end
      end
      add_text(txt);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned n_chars, input bit long_hold);
      int unsigned target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (long_hold) hold_requests++;
      target = queued_chars + n_chars;
      while (queued_chars < target) add_random_address();
      while (char_feed.size() != 0 || req_valid) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (char_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= char_feed.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) parse_char(req_data);
         if (rsp_valid && !rsp_stall) begin
            quads_checked++;
            if (rsp_data.addr_valid) quads_valid++;
            if (want_quads.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("Unexpected result transaction: %0d.%0d.%0d.%0d valid %0b",
                           rsp_data.octet_a, rsp_data.octet_b, rsp_data.octet_c,
                           rsp_data.octet_d, rsp_data.addr_valid);
            end else begin
               want = want_quads.pop_front();
               if (rsp_data.octet_a !== want.octet_a || rsp_data.octet_b !== want.octet_b ||
                   rsp_data.octet_c !== want.octet_c || rsp_data.octet_d !== want.octet_d ||
                   rsp_data.addr_valid !== want.addr_valid) begin
                  faults++;
                  if (faults <= 10)
                     $display("Mismatch: expected %0d.%0d.%0d.%0d valid %0b, got %0d.%0d.%0d.%0d valid %0b",
                              want.octet_a, want.octet_b, want.octet_c, want.octet_d,
                              want.addr_valid, rsp_data.octet_a, rsp_data.octet_b,
                              rsp_data.octet_c, rsp_data.octet_d, rsp_data.addr_valid);
               end
            end
         end
      end
   end

   initial begin
      char_q_type odd_byte;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_string("0.0.0.0");
      add_string("255.255.255.255");
      add_string("1.2.3.4.");
      add_string("9.300.1.2");
      odd_byte = '{8'h00};
      add_text(odd_byte);
      odd_byte = '{8'hFF};
      add_text(odd_byte);
      while (char_feed.size() != 0 || req_valid) @(posedge clock);

      run_phase(0, 0, 100, 1'b1);
      run_phase(56, 0, 100, 1'b0);
      run_phase(0, 56, 100, 1'b0);
      run_phase(11, 11, 100, 1'b0);

      while (want_quads.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d characters and checked %0d addresses, %0d of them well formed,",
               queued_chars, quads_checked, quads_valid);
      $display("under four idling mixes and one long hold-off on the result side.");
      if (faults == 0 && want_quads.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
